// ===== rtl/rtccal_pkg.sv =====
// shared types, register codes and calendar helpers for the rtc calendar block
package rtccal_pkg;

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // register map
  localparam logic [3:0] REG_SEC     = 4'd0;
  localparam logic [3:0] REG_MIN     = 4'd1;
  localparam logic [3:0] REG_HOUR    = 4'd2;
  localparam logic [3:0] REG_DAY     = 4'd3;
  localparam logic [3:0] REG_MONTH   = 4'd4;
  localparam logic [3:0] REG_YEAR    = 4'd5;
  localparam logic [3:0] REG_CTRL    = 4'd6;
  localparam logic [3:0] REG_STATUS  = 4'd7;
  localparam logic [3:0] REG_AL_SEC  = 4'd8;
  localparam logic [3:0] REG_AL_MIN  = 4'd9;
  localparam logic [3:0] REG_AL_HOUR = 4'd10;
  localparam logic [3:0] REG_AL_EN   = 4'd11;
  localparam logic [3:0] REG_PERIOD  = 4'd12;
  localparam logic [3:0] REG_RESET   = 4'd13;

  // control bit positions
  localparam int CTRL_EN   = 0;
  localparam int CTRL_HALT = 1;
  localparam int CTRL_TM   = 2;
  localparam int CTRL_PIE  = 3;
  localparam int CTRL_AIE  = 4;

  // status bit positions
  localparam int ST_INV = 0;
  localparam int ST_AF  = 1;
  localparam int ST_PF  = 2;

  // calendar limits
  localparam logic [15:0] YEAR_MAX   = 16'd9999;
  localparam logic [13:0] YEAR_RESET = 14'd2000;
  localparam logic [7:0]  SEC_MAX    = 8'd59;
  localparam logic [7:0]  HOUR_MAX   = 8'd23;
  localparam logic [7:0]  MONTH_MAX  = 8'd12;
  localparam logic [15:0] UNKNOWN_RD = 16'h00ff;

  // one accepted item
  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  reg_index;
    logic [15:0] write_data;
    logic        wide_access;
  } item_t;

  // one result item
  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_raise;
    logic        write_rejected;
  } result_t;

  // days in a month, zero for a month number that is out of range
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    unique case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  // alarm compare on the enabled fields, never matches with none enabled
  function automatic logic alarm_match(input logic [2:0] en,
                                       input logic [5:0] s, input logic [5:0] m,
                                       input logic [4:0] h, input logic [5:0] as,
                                       input logic [5:0] am, input logic [4:0] ah);
    logic hit;
    hit = (en != 3'd0);
    if (en[0] && (s != as)) hit = 1'b0;
    if (en[1] && (m != am)) hit = 1'b0;
    if (en[2] && (h != ah)) hit = 1'b0;
    return hit;
  endfunction

endpackage

// ===== rtl/rtccal_leap.sv =====
// gregorian leap year test using a reciprocal multiply for the century split
module rtccal_leap (
  input  logic [13:0] year,
  output logic        leap
);
  import rtccal_pkg::*;

  logic [26:0] prod;
  logic [7:0]  cent;
  logic [14:0] cent_x100;
  logic [13:0] rem100;

  // year / 100 as (year * 5243) >> 19, exact over 14 bits
  assign prod      = {13'd0, year} * 27'd5243;
  assign cent      = prod[26:19];
  assign cent_x100 = {7'd0, cent} * 15'd100;
  assign rem100    = year - cent_x100[13:0];

  // divisible by 4, and not a century unless the century is divisible by 4
  assign leap = (year[1:0] == 2'd0) && ((rem100 != 14'd0) || (cent[1:0] == 2'd0));

endmodule

// ===== rtl/rtccal_core.sv =====
// clock, calendar, alarm and period state with the per-item update logic
module rtccal_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  rtccal_pkg::item_t   item,
  output rtccal_pkg::result_t result
);
  import rtccal_pkg::*;

  logic [5:0]  seconds, seconds_next;
  logic [5:0]  minutes, minutes_next;
  logic [4:0]  hours, hours_next;
  logic [4:0]  day_of_month, day_of_month_next;
  logic [3:0]  month_number, month_number_next;
  logic [13:0] year_number, year_number_next;
  logic [7:0]  control_bits, control_bits_next;
  logic [2:0]  status_flags, status_flags_next;
  logic [5:0]  alarm_seconds, alarm_seconds_next;
  logic [5:0]  alarm_minutes, alarm_minutes_next;
  logic [4:0]  alarm_hours, alarm_hours_next;
  logic [2:0]  alarm_enables, alarm_enables_next;
  logic [7:0]  period_length, period_length_next;
  logic [7:0]  period_countdown, period_countdown_next;
  logic        previous_match, previous_match_next;

  logic [7:0]  wv;
  logic [15:0] year_cand;
  logic        year_wr;
  logic [13:0] leap_year_in;
  logic        leap;
  logic [4:0]  dim_cur;
  logic [4:0]  dim_new_month;
  logic        time_cur_ok;
  logic        date_cur_ok;
  logic        wr_ok;
  logic        run;
  logic [7:0]  interval;
  logic [7:0]  count;
  logic        match;

  assign wv        = item.write_data[7:0];
  assign year_cand = item.wide_access ? item.write_data : {2'b00, year_number[13:8], wv};
  assign year_wr   = (item.opcode == OP_WRITE) && (item.reg_index == REG_YEAR);

  // one leap unit, fed with the candidate year on a year write
  assign leap_year_in = year_wr ? year_cand[13:0] : year_number;

  rtccal_leap u_leap (
    .year (leap_year_in),
    .leap (leap)
  );

  // range checks on the current time and date
  assign dim_cur       = month_days(month_number, leap);
  assign dim_new_month = month_days(wv[3:0], leap);
  assign time_cur_ok   = ({2'b00, seconds} <= SEC_MAX) && ({2'b00, minutes} <= SEC_MAX) &&
                         ({3'b000, hours} <= HOUR_MAX);
  assign date_cur_ok   = ({2'b00, year_number} <= YEAR_MAX) && (month_number != 4'd0) &&
                         ({4'd0, month_number} <= MONTH_MAX) && (day_of_month != 5'd0) &&
                         (day_of_month <= dim_cur);
  assign run           = control_bits[CTRL_EN] && !control_bits[CTRL_HALT] &&
                         !control_bits[CTRL_TM];
  assign interval      = (period_length != 8'd0) ? period_length : 8'd1;

  // next state and result for the item in hand
  always_comb begin
    seconds_next          = seconds;
    minutes_next          = minutes;
    hours_next            = hours;
    day_of_month_next     = day_of_month;
    month_number_next     = month_number;
    year_number_next      = year_number;
    control_bits_next     = control_bits;
    status_flags_next     = status_flags;
    alarm_seconds_next    = alarm_seconds;
    alarm_minutes_next    = alarm_minutes;
    alarm_hours_next      = alarm_hours;
    alarm_enables_next    = alarm_enables;
    period_length_next    = period_length;
    period_countdown_next = period_countdown;
    previous_match_next   = previous_match;
    result                = '0;
    wr_ok                 = 1'b1;
    count                 = period_countdown;
    match                 = 1'b0;

    unique case (item.opcode)
      OP_TICK: begin
        if (run) begin
          // carry chain through the calendar
          if (seconds >= 6'd59) begin
            seconds_next = 6'd0;
            if (minutes >= 6'd59) begin
              minutes_next = 6'd0;
              if (hours >= 5'd23) begin
                hours_next = 5'd0;
                if (day_of_month >= dim_cur) begin
                  day_of_month_next = 5'd1;
                  if (month_number >= 4'd12) begin
                    month_number_next = 4'd1;
                    if ({2'b00, year_number} >= YEAR_MAX) year_number_next = 14'd0;
                    else year_number_next = year_number + 14'd1;
                  end else begin
                    month_number_next = month_number + 4'd1;
                  end
                end else begin
                  day_of_month_next = day_of_month + 5'd1;
                end
              end else begin
                hours_next = hours + 5'd1;
              end
            end else begin
              minutes_next = minutes + 6'd1;
            end
          end else begin
            seconds_next = seconds + 6'd1;
          end
          // period countdown
          if (control_bits[CTRL_PIE]) begin
            if (count == 8'd0) count = interval;
            count = count - 8'd1;
            if (count == 8'd0) begin
              status_flags_next[ST_PF] = 1'b1;
              result.irq_raise         = 1'b1;
              count                    = interval;
            end
            period_countdown_next = count;
          end
          // alarm edge
          match = alarm_match(alarm_enables, seconds_next, minutes_next, hours_next,
                              alarm_seconds, alarm_minutes, alarm_hours);
          if (match && !previous_match) begin
            status_flags_next[ST_AF] = 1'b1;
            if (control_bits[CTRL_AIE]) result.irq_raise = 1'b1;
          end
          previous_match_next = match;
        end
      end
      OP_READ: begin
        unique case (item.reg_index)
          REG_SEC:     result.read_data = {10'd0, seconds};
          REG_MIN:     result.read_data = {10'd0, minutes};
          REG_HOUR:    result.read_data = {11'd0, hours};
          REG_DAY:     result.read_data = {11'd0, day_of_month};
          REG_MONTH:   result.read_data = {12'd0, month_number};
          REG_YEAR:    result.read_data = item.wide_access ? {2'b00, year_number}
                                                           : {8'd0, year_number[7:0]};
          REG_CTRL:    result.read_data = {8'd0, control_bits};
          REG_STATUS:  result.read_data = {13'd0, status_flags};
          REG_AL_SEC:  result.read_data = {10'd0, alarm_seconds};
          REG_AL_MIN:  result.read_data = {10'd0, alarm_minutes};
          REG_AL_HOUR: result.read_data = {11'd0, alarm_hours};
          REG_AL_EN:   result.read_data = {13'd0, alarm_enables};
          REG_PERIOD:  result.read_data = {8'd0, period_length};
          default:     result.read_data = UNKNOWN_RD;
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_index)
          REG_SEC: begin
            wr_ok = (wv <= SEC_MAX) && time_cur_ok && date_cur_ok;
            if (wr_ok) seconds_next = wv[5:0];
          end
          REG_MIN: begin
            wr_ok = (wv <= SEC_MAX) && time_cur_ok && date_cur_ok;
            if (wr_ok) minutes_next = wv[5:0];
          end
          REG_HOUR: begin
            wr_ok = (wv <= HOUR_MAX) && time_cur_ok && date_cur_ok;
            if (wr_ok) hours_next = wv[4:0];
          end
          REG_DAY: begin
            wr_ok = time_cur_ok && ({2'b00, year_number} <= YEAR_MAX) &&
                    (month_number != 4'd0) && ({4'd0, month_number} <= MONTH_MAX) &&
                    (wv != 8'd0) && (wv <= {3'b000, dim_cur});
            if (wr_ok) day_of_month_next = wv[4:0];
          end
          REG_MONTH: begin
            wr_ok = time_cur_ok && ({2'b00, year_number} <= YEAR_MAX) &&
                    (wv != 8'd0) && (wv <= MONTH_MAX) && (day_of_month != 5'd0) &&
                    (day_of_month <= dim_new_month);
            if (wr_ok) month_number_next = wv[3:0];
          end
          REG_YEAR: begin
            wr_ok = (year_cand <= YEAR_MAX) && (month_number != 4'd0) &&
                    ({4'd0, month_number} <= MONTH_MAX) && (day_of_month != 5'd0) &&
                    (day_of_month <= dim_cur);
            if (wr_ok) year_number_next = year_cand[13:0];
          end
          REG_CTRL:    control_bits_next  = wv;
          REG_STATUS:  status_flags_next  = status_flags & ~wv[2:0];
          REG_AL_SEC: begin
            wr_ok = (wv <= SEC_MAX);
            if (wr_ok) alarm_seconds_next = wv[5:0];
          end
          REG_AL_MIN: begin
            wr_ok = (wv <= SEC_MAX);
            if (wr_ok) alarm_minutes_next = wv[5:0];
          end
          REG_AL_HOUR: begin
            wr_ok = (wv <= HOUR_MAX);
            if (wr_ok) alarm_hours_next = wv[4:0];
          end
          REG_AL_EN:   alarm_enables_next = wv[2:0];
          REG_PERIOD: begin
            period_length_next    = wv;
            period_countdown_next = (wv != 8'd0) ? wv : 8'd1;
          end
          REG_RESET: begin
            seconds_next          = 6'd0;
            minutes_next          = 6'd0;
            hours_next            = 5'd0;
            day_of_month_next     = 5'd1;
            month_number_next     = 4'd1;
            year_number_next      = YEAR_RESET;
            control_bits_next     = 8'd0;
            status_flags_next     = 3'd0;
            alarm_seconds_next    = 6'd0;
            alarm_minutes_next    = 6'd0;
            alarm_hours_next      = 5'd0;
            alarm_enables_next    = 3'd0;
            period_length_next    = 8'd0;
            period_countdown_next = 8'd1;
            previous_match_next   = 1'b0;
          end
          default: result.write_rejected = 1'b1;
        endcase
        // known registers other than reset: flag a bad value or resync the alarm edge
        if (item.reg_index <= REG_PERIOD) begin
          if (!wr_ok) begin
            status_flags_next[ST_INV] = 1'b1;
            result.write_rejected     = 1'b1;
          end else begin
            previous_match_next = alarm_match(alarm_enables_next, seconds_next,
                                              minutes_next, hours_next,
                                              alarm_seconds_next, alarm_minutes_next,
                                              alarm_hours_next);
          end
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds          <= 6'd0;
      minutes          <= 6'd0;
      hours            <= 5'd0;
      day_of_month     <= 5'd1;
      month_number     <= 4'd1;
      year_number      <= YEAR_RESET;
      control_bits     <= 8'd0;
      status_flags     <= 3'd0;
      alarm_seconds    <= 6'd0;
      alarm_minutes    <= 6'd0;
      alarm_hours      <= 5'd0;
      alarm_enables    <= 3'd0;
      period_length    <= 8'd0;
      period_countdown <= 8'd1;
      previous_match   <= 1'b0;
    end else if (fire) begin
      seconds          <= seconds_next;
      minutes          <= minutes_next;
      hours            <= hours_next;
      day_of_month     <= day_of_month_next;
      month_number     <= month_number_next;
      year_number      <= year_number_next;
      control_bits     <= control_bits_next;
      status_flags     <= status_flags_next;
      alarm_seconds    <= alarm_seconds_next;
      alarm_minutes    <= alarm_minutes_next;
      alarm_hours      <= alarm_hours_next;
      alarm_enables    <= alarm_enables_next;
      period_length    <= period_length_next;
      period_countdown <= period_countdown_next;
      previous_match   <= previous_match_next;
    end
  end

endmodule

// ===== rtl/rtc_calendar_device_core.sv =====
// top level of the rtc calendar block: input register, state core, result register
//
// Usage: each item on the slave stream is a one-second tick, a register read or a
// register write; s_tuser carries the operation code and s_tdata the register
// number, write value and access width. Every item gives exactly one result item
// on the master stream with the read value, an interrupt flag for ticks and a
// rejected flag for writes.
// Flow: an accepted item is registered in the input register, processed against
// the clock state by the core and its result is captured in the result register,
// from which it is presented; while the result register is full and m_tready is
// low, the item waits in the input register.
// Throughput: one item per clock while m_tready is high; the whole update of the
// calendar, alarm and period countdown for an item is done combinationally between
// the input register and the result register.
// Reset: rst clears both stages and sets the time to 2000-01-01 00:00:00 with all
// control, status, alarm and period registers at their defaults.
// Stall: while m_tready is low the result is held; one more item can still be
// taken into the input register, after which s_tready stays low until the
// result is taken.
module rtc_calendar_device_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // reg_index[3:0], write_data[19:4], wide_access[20], zero pad
  input  logic [1:0]  s_tuser,  // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // read_data[15:0], irq_raise[16], write_rejected[17], zero pad
);
  import rtccal_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_result;
  result_t core_result;
  logic    adv;
  logic    s_fire;

  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;
  assign s_fire   = s_tvalid && s_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_item.opcode      <= s_tuser;
      in_item.reg_index   <= s_tdata[3:0];
      in_item.write_data  <= s_tdata[19:4];
      in_item.wide_access <= s_tdata[20];
    end
  end

  rtccal_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (adv),
    .item   (in_item),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_result.write_rejected, out_result.irq_raise,
                     out_result.read_data};

endmodule
